// ===== rtl/utf8_stream_decoder_defines.svh =====
// assertion macros for the utf8 stream decoder core rtl
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define U8D_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define U8D_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/u8dec_pkg.sv =====
// shared widths and beat types for the utf8 stream decoder
package u8dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 26;
    localparam int CNT_W   = 3;
    localparam int TDATA_W = 32;
    localparam int PAD_W   = TDATA_W - CP_W;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp_val;
    } t_result;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_LEAD5,
        KIND_BAD
    } t_byte_kind;

endpackage

// ===== rtl/u8dec_in_stage.sv =====
// input register for the raw byte stream
module u8dec_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [u8dec_pkg::BYTE_W-1:0]  i_data,
    output logic                          o_ready,
    input  logic                          i_adv,
    output u8dec_pkg::t_beat              o_beat
);
    import u8dec_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

// ===== rtl/u8dec_core.sv =====
// decode state and per-byte update logic
`include "utf8_stream_decoder_defines.svh"

module u8dec_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8dec_pkg::t_beat   i_beat,
    input  logic               i_adv,
    output u8dec_pkg::t_result o_res
);
    import u8dec_pkg::*;

    localparam int          CONT_BITS   = 6;
    localparam logic [CNT_W-1:0] MAX_PENDING = CNT_W'(4);

    logic [CP_W-1:0]  r_partial;
    logic [CNT_W-1:0] r_pending;
    logic [CP_W-1:0]  n_partial;
    logic [CNT_W-1:0] n_pending;
    t_byte_kind       kind;
    logic [BYTE_W-1:0] b;

    assign b = i_beat.data;

    always_comb begin
        priority if (b[7] == 1'b0)          kind = KIND_ASCII;
        else if (b[7:6] == 2'b10)           kind = KIND_CONT;
        else if (b[7:5] == 3'b110)          kind = KIND_LEAD2;
        else if (b[7:4] == 4'b1110)         kind = KIND_LEAD3;
        else if (b[7:3] == 5'b11110)        kind = KIND_LEAD4;
        else if (b[7:2] == 6'b111110)       kind = KIND_LEAD5;
        else                                kind = KIND_BAD;
    end

    always_comb begin
        n_partial    = r_partial;
        n_pending    = r_pending;
        o_res.valid  = 1'b0;
        o_res.cp_val = {r_partial[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
        if (kind == KIND_CONT) begin
            // stray continuation with nothing pending is dropped
            if (r_pending != '0) begin
                n_partial   = {r_partial[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
                n_pending   = r_pending - CNT_W'(1);
                o_res.valid = i_beat.valid && (r_pending == CNT_W'(1));
            end
        end else if (r_pending != '0) begin
            // broken sequence: abandon it and drop this byte
            n_pending = '0;
        end else begin
            unique case (kind)
                KIND_ASCII: begin
                    o_res.valid  = i_beat.valid;
                    o_res.cp_val = CP_W'(b);
                end
                KIND_LEAD2: begin
                    n_partial = CP_W'(b[4:0]);
                    n_pending = CNT_W'(1);
                end
                KIND_LEAD3: begin
                    n_partial = CP_W'(b[3:0]);
                    n_pending = CNT_W'(2);
                end
                KIND_LEAD4: begin
                    n_partial = CP_W'(b[2:0]);
                    n_pending = CNT_W'(3);
                end
                KIND_LEAD5: begin
                    n_partial = CP_W'(b[1:0]);
                    n_pending = MAX_PENDING;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= '0;
        end else if (i_adv) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

    `U8D_ASSERT_IMP(a_pending_range, 1'b1, r_pending <= MAX_PENDING, "pending count out of range")
    `U8D_ASSERT_NXT(a_done_clears, i_adv && o_res.valid, r_pending == '0, "pending left after result")
    `U8D_ASSERT_NXT(a_hold_state, !i_adv, $stable(r_pending) && $stable(r_partial), "state moved on stall")
    `U8D_ASSERT_IMP(a_ascii_result, i_beat.valid && r_pending == '0 && !b[7], o_res.valid, "ascii byte gave no result")

endmodule

// ===== rtl/u8dec_out_stage.sv =====
// result register toward the code point stream
module u8dec_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [u8dec_pkg::CP_W-1:0]      i_cp_val,
    output logic                            o_free,
    output logic                            o_valid,
    output logic [u8dec_pkg::TDATA_W-1:0]   o_data,
    input  logic                            i_ready
);
    import u8dec_pkg::*;

    logic            r_valid;
    logic [CP_W-1:0] r_cp_val;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp_val <= i_cp_val;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{PAD_W{1'b0}}, r_cp_val};

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// utf8 byte stream to code point stream decoder, top level
//
//  channel   dir  tdata bits             notes
//  s_axis    in   [7:0] byte_in          one raw byte per beat
//  m_axis    out  [25:0] cp_val          [31:26] zero, one beat per finished character
//
// one byte per cycle sustained unless a stalled result holds a byte; a byte passes
// input register, decode logic and result register in that order
// the per-byte update of the pending count and partial value is the only loop
// reset (synchronous, active low) clears pending count, partial value and both valid flags
// bytes that give no result never wait on m_axis; a stalled result holds the
// input register only when the next byte would also produce a result
module utf8_stream_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [u8dec_pkg::BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] byte_in
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [u8dec_pkg::TDATA_W-1:0]     o_m_axis_tdata    // [25:0] cp_val, [31:26] zero
);
    import u8dec_pkg::*;

    t_beat   beat;
    t_result res;
    logic    out_free;
    logic    adv;

    assign adv = beat.valid && (!res.valid || out_free);

    u8dec_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .i_adv   (adv),
        .o_beat  (beat)
    );

    u8dec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_adv   (adv),
        .o_res   (res)
    );

    u8dec_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && res.valid),
        .i_cp_val (res.cp_val),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata),
        .i_ready  (i_m_axis_tready)
    );

endmodule
